// File: hw/rtl/rcbd_pkg.sv
// ----------------------------------------------------------------------------
// rcbd_pkg - shared definitions for the rotate/centre/Bayer dither placer
// Screen geometry, register indexes, placement bundle and the 8x8 Bayer table.
// ----------------------------------------------------------------------------
package rcbd_pkg;

  localparam int unsigned SCREEN_WIDTH  = 960;
  localparam int unsigned SCREEN_HEIGHT = 540;
  localparam bit          SCREEN_LANDSCAPE = (SCREEN_WIDTH > SCREEN_HEIGHT);

  // signed screen coordinate width: offsets plus scaled image span
  localparam int unsigned COORD_W = 16;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_PORTRAIT_MODE = 2'd2
  } cfg_idx_t;

  // placement derived from the configuration registers
  typedef struct packed {
    logic        rot;
    logic        wide;
    logic [12:0] sw;
    logic [12:0] sh;
    logic [9:0]  off_x;
    logic [9:0]  off_y;
  } place_t;

  localparam logic [5:0] BAYER_TAB [64] = '{
     6'd0, 6'd32,  6'd8, 6'd40,  6'd2, 6'd34, 6'd10, 6'd42,
    6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
    6'd12, 6'd44,  6'd4, 6'd36, 6'd14, 6'd46,  6'd6, 6'd38,
    6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
     6'd3, 6'd35, 6'd11, 6'd43,  6'd1, 6'd33,  6'd9, 6'd41,
    6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
    6'd15, 6'd47,  6'd7, 6'd39, 6'd13, 6'd45,  6'd5, 6'd37,
    6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
  };

  // threshold = table value * 4 + 2
  function automatic logic [7:0] dither_thr(input logic [2:0] row, input logic [2:0] col);
    dither_thr = {BAYER_TAB[{row, col}], 2'b10};
  endfunction

endpackage

// File: hw/rtl/rotate_center_bayer_dither_pixel_top.sv
// ----------------------------------------------------------------------------
// rotate_center_bayer_dither_pixel_top - ordered dither pixel placer
// Places one scaled image pixel on the panel (rotate, downscale, centre,
// optional portrait turn) and thresholds its luma against an 8x8 Bayer cell.
// ----------------------------------------------------------------------------
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+--------------------
//  input   | in_image_x, in_image_y, in_luma              | start && !busy
//  result  | out_panel_x, out_panel_y, out_pixel_white,   | out_valid, 1 cycle
//          | out_visible                                  |
//  config  | cfg_index, cfg_wdata                         | cfg_we
//
//  One transaction per cycle; each accepted transaction passes the input register,
//  then the result register. busy is never raised.
//  Placement values are re-derived from the config registers every cycle.
//  rst_n (synchronous) restores image size 1x1, landscape, and empties the pipe.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module rotate_center_bayer_dither_pixel_top
  import rcbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [12:0] in_image_x,
  input  logic [12:0] in_image_y,
  input  logic [7:0]  in_luma,
  output logic        out_valid,
  output logic [9:0]  out_panel_x,
  output logic [9:0]  out_panel_y,
  output logic        out_pixel_white,
  output logic        out_visible,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic signed [COORD_W-1:0] SW_S = COORD_W'(SCREEN_WIDTH);
  localparam logic signed [COORD_W-1:0] SH_S = COORD_W'(SCREEN_HEIGHT);
  localparam logic [9:0] SW_M1 = 10'(SCREEN_WIDTH - 1);
  localparam int unsigned SCREEN_MAX =
    (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;

  // configuration
  logic [15:0] img_w_r, img_h_r;
  logic        portrait_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r    <= 16'd1;
      img_h_r    <= 16'd1;
      portrait_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:   img_w_r    <= cfg_wdata;
        CFG_IMAGE_HEIGHT:  img_h_r    <= cfg_wdata;
        CFG_PORTRAIT_MODE: portrait_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // placement from configuration
  place_t      place_r, place_nxt;
  logic [9:0]  fit_w, fit_h;
  logic [16:0] w17, h17, fw17, fh17;
  logic [1:0]  div_log;
  logic [15:0] sw_full, sh_full;
  logic [12:0] disp_w, disp_h;
  logic signed [14:0] span_x, span_y;

  always_comb begin
    place_nxt.wide = img_w_r > img_h_r;
    place_nxt.rot  = place_nxt.wide ^ SCREEN_LANDSCAPE;
    fit_w = place_nxt.rot ? 10'(SCREEN_HEIGHT) : 10'(SCREEN_WIDTH);
    fit_h = place_nxt.rot ? 10'(SCREEN_WIDTH)  : 10'(SCREEN_HEIGHT);
    w17  = {1'b0, img_w_r};
    h17  = {1'b0, img_h_r};
    fw17 = {7'd0, fit_w};
    fh17 = {7'd0, fit_h};
    priority if (w17 > (fw17 << 2) || h17 > (fh17 << 2)) div_log = 2'd3;
    else if (w17 > (fw17 << 1) || h17 > (fh17 << 1))     div_log = 2'd2;
    else if (w17 > fw17 || h17 > fh17)                   div_log = 2'd1;
    else                                                 div_log = 2'd0;
    sw_full = img_w_r >> div_log;
    sh_full = img_h_r >> div_log;
    place_nxt.sw = sw_full[12:0];
    place_nxt.sh = sh_full[12:0];
    disp_w = place_nxt.rot ? place_nxt.sh : place_nxt.sw;
    disp_h = place_nxt.rot ? place_nxt.sw : place_nxt.sh;
    span_x = $signed(15'(SCREEN_WIDTH))  - $signed({2'b00, disp_w});
    span_y = $signed(15'(SCREEN_HEIGHT)) - $signed({2'b00, disp_h});
    // centring offset clamps at zero
    place_nxt.off_x = (span_x > 15'sd0) ? span_x[10:1] : 10'd0;
    place_nxt.off_y = (span_y > 15'sd0) ? span_y[10:1] : 10'd0;
  end

  always_ff @(posedge clk) begin
    place_r <= place_nxt;
  end

  // input register
  logic        accept;
  logic        in_vld_r;
  logic [12:0] ix_r, iy_r;
  logic [7:0]  luma_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ix_r   <= in_image_x;
      iy_r   <= in_image_y;
      luma_r <= in_luma;
    end
  end

  // screen mapping, dither and panel turn
  logic signed [COORD_W-1:0] ix_s, iy_s, offx_s, offy_s, sw_s, sh_s, sx, sy;
  logic       vis;
  logic [7:0] thr;
  logic [9:0] px, py;
  logic       white;

  always_comb begin
    ix_s   = $signed({3'd0, ix_r});
    iy_s   = $signed({3'd0, iy_r});
    offx_s = $signed({6'd0, place_r.off_x});
    offy_s = $signed({6'd0, place_r.off_y});
    sw_s   = $signed({3'd0, place_r.sw});
    sh_s   = $signed({3'd0, place_r.sh});
    if (place_r.rot && place_r.wide) begin
      // clockwise
      sx = offx_s + sh_s - 16'sd1 - iy_s;
      sy = offy_s + ix_s;
    end else if (place_r.rot) begin
      // counter-clockwise
      sx = offx_s + iy_s;
      sy = offy_s + sw_s - 16'sd1 - ix_s;
    end else begin
      sx = offx_s + ix_s;
      sy = offy_s + iy_s;
    end
    vis   = (sx >= 16'sd0) && (sy >= 16'sd0) && (sx < SW_S) && (sy < SH_S);
    thr   = dither_thr(sy[2:0], sx[2:0]);
    white = vis && (luma_r > thr);
    if (!vis) begin
      px = 10'd0;
      py = 10'd0;
    end else if (portrait_r) begin
      px = sy[9:0];
      py = SW_M1 - sx[9:0];
    end else begin
      px = sx[9:0];
      py = sy[9:0];
    end
  end

  // result register
  logic       out_valid_r;
  logic [9:0] out_px_r, out_py_r;
  logic       out_white_r, out_vis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_px_r    <= px;
      out_py_r    <= py;
      out_white_r <= white;
      out_vis_r   <= vis;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_panel_x     = out_px_r;
  assign out_panel_y     = out_py_r;
  assign out_pixel_white = out_white_r;
  assign out_visible     = out_vis_r;

  // checks
  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result without accepted transaction");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_valid)
    else $error("accepted transaction lost");

  a_clipped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_visible) |->
      (out_panel_x == 10'd0 && out_panel_y == 10'd0 && !out_pixel_white))
    else $error("clipped result carries non-zero fields");

  a_panel_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_visible) |->
      (out_panel_x < 10'(SCREEN_MAX) && out_panel_y < 10'(SCREEN_MAX)))
    else $error("visible pixel off panel");

endmodule
